@@ hdl/npna_pkg.sv @@
`default_nettype none
package npna_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int ACC_W       = 64;
  localparam int MAG_W       = 63;
  localparam int SQ_W        = 128;
  localparam int ROOT_W      = 64;
  localparam int UNIT_SHIFT  = 30;
  localparam int DVD_W       = 31 + UNIT_SHIFT;
  localparam int CNT_W       = 7;
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DVD_W - 1);
  localparam logic [DVD_W-1:0] FLUSH_LIMIT = DVD_W'(107375);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL0, S_ADD0, S_MUL1, S_ADD1, S_EMIT, S_SQ_INIT, S_SQ_MUL, S_SQ_ACC,
    S_SQRT_INIT, S_SQRT, S_AREA, S_SHIFT, S_DIV_INIT, S_DIV, S_DIV_SAVE, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_VERTEX, CMD_PAIR_MUL, CMD_PAIR_ADD, CMD_EMIT, CMD_SQ_INIT, CMD_SQ_MUL,
    CMD_SQ_ACC, CMD_SQRT_INIT, CMD_SQRT, CMD_AREA, CMD_SHIFT, CMD_DIV_INIT, CMD_DIV,
    CMD_DIV_SAVE, CMD_OUT
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic pair_sel;   // 0: (previous, current), 1: (current, first)
  } ctrl_t;

  typedef struct packed {
    logic started;
    logic last;       // last flag of the latched vertex
    logic last_in;    // last flag on the input port
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic div_last;
    logic shift_done;
    logic unit_req;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/npna_ctrl.sv @@
`default_nettype none
module npna_ctrl import npna_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state, state_next;
  logic   second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next    = state;
    second_next   = second;
    ctrl.cmd      = CMD_NONE;
    ctrl.pair_sel = 1'b0;
    s_tready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.cmd = CMD_VERTEX;
          if (status.started) state_next = S_MUL0;
          else if (status.last_in) state_next = S_MUL1;
        end
      end
      S_MUL0: begin
        ctrl.cmd   = CMD_PAIR_MUL;
        state_next = S_ADD0;
      end
      S_ADD0: begin
        ctrl.cmd   = CMD_PAIR_ADD;
        state_next = status.last ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        ctrl.cmd      = CMD_PAIR_MUL;
        ctrl.pair_sel = 1'b1;
        state_next    = S_ADD1;
      end
      S_ADD1: begin
        ctrl.cmd      = CMD_PAIR_ADD;
        ctrl.pair_sel = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        ctrl.cmd    = CMD_EMIT;
        second_next = 1'b0;
        state_next  = S_SQ_INIT;
      end
      S_SQ_INIT: begin
        ctrl.cmd   = CMD_SQ_INIT;
        state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        ctrl.cmd   = CMD_SQ_MUL;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        ctrl.cmd   = CMD_SQ_ACC;
        state_next = status.sq_done ? S_SQRT_INIT : S_SQ_MUL;
      end
      S_SQRT_INIT: begin
        ctrl.cmd   = CMD_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        ctrl.cmd = CMD_SQRT;
        if (status.sqrt_done) state_next = second ? S_DIV_INIT : S_AREA;
      end
      S_AREA: begin
        ctrl.cmd   = CMD_AREA;
        state_next = status.unit_req ? S_SHIFT : S_OUT;
      end
      S_SHIFT: begin
        if (status.shift_done) begin
          second_next = 1'b1;
          state_next  = S_SQ_INIT;
        end else begin
          ctrl.cmd = CMD_SHIFT;
        end
      end
      S_DIV_INIT: begin
        ctrl.cmd   = CMD_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctrl.cmd = CMD_DIV;
        if (status.div_done) state_next = S_DIV_SAVE;
      end
      S_DIV_SAVE: begin
        ctrl.cmd   = CMD_DIV_SAVE;
        state_next = status.div_last ? S_OUT : S_DIV_INIT;
      end
      S_OUT: begin
        if (status.out_free) begin
          ctrl.cmd   = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/npna_datapath.sv @@
`default_nettype none
module npna_datapath import npna_pkg::*; (
  input  wire                          clk,
  input  wire                          rst,
  input  ctrl_t                        ctrl,
  output status_t                      status,
  input  wire                          cfg_wen,
  input  wire                          cfg_wdata,
  input  wire signed [COORD_WIDTH-1:0] in_x,
  input  wire signed [COORD_WIDTH-1:0] in_y,
  input  wire signed [COORD_WIDTH-1:0] in_z,
  input  wire                          in_last,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [ACC_W-1:0]      out_nx,
  output logic signed [ACC_W-1:0]      out_ny,
  output logic signed [ACC_W-1:0]      out_nz,
  output logic [MAG_W-1:0]             out_area,
  output logic                         out_ovf
);

  logic                          normalize;
  logic                          started, last, sat, ovf_keep;
  logic signed [COORD_WIDTH-1:0] cur [3];
  logic signed [COORD_WIDTH-1:0] first [3];
  logic signed [COORD_WIDTH-1:0] prev [3];
  logic signed [PROD_W-1:0]      term [3];
  logic signed [ACC_W-1:0]       sums [3];
  logic [MAG_W-1:0]              mag [3];
  logic                          neg [3];
  logic [1:0]                    comp, part;
  logic [ACC_W-1:0]              prod;
  logic [SQ_W-1:0]               acc, num;
  logic [ROOT_W+2:0]             rem;
  logic [ROOT_W-1:0]             root;
  logic [CNT_W-1:0]              cnt;
  logic [DVD_W-1:0]              dvd, quo;
  logic [31:0]                   drem;
  logic [MAG_W-1:0]              area_r;

  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COORD_WIDTH-1:0] q [3];
  logic signed [DIFF_W-1:0]      dif [3];
  logic signed [DIFF_W-1:0]      add [3];
  logic signed [ACC_W:0]         wsum [3];
  logic [2:0]                    wovf;
  logic [MAG_W-1:0]              orv, msel;
  logic [31:0]                   op_a, op_b;
  logic [ROOT_W+2:0]             rem_sh, trial;
  logic [32:0]                   drs;
  logic                          dge;
  logic [ACC_W-1:0]              absv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = ctrl.pair_sel ? cur[i] : prev[i];
      q[i] = ctrl.pair_sel ? first[i] : cur[i];
    end
    // Newell terms: x uses (y,z), y uses (z,x), z uses (x,y)
    for (int i = 0; i < 3; i++) begin
      dif[i] = DIFF_W'(p[(i+1)%3]) - DIFF_W'(q[(i+1)%3]);
      add[i] = DIFF_W'(p[(i+2)%3]) + DIFF_W'(q[(i+2)%3]);
      wsum[i] = {sums[i][ACC_W-1], sums[i]} + (ACC_W+1)'(term[i]);
      wovf[i] = wsum[i][ACC_W] != wsum[i][ACC_W-1];
      absv[i] = sums[i][ACC_W-1] ? ACC_W'(-sums[i]) : ACC_W'(sums[i]);
    end
    orv  = mag[0] | mag[1] | mag[2];
    msel = mag[comp];
    op_a = (part == 2'd0) ? msel[31:0] : {1'b0, msel[MAG_W-1:32]};
    op_b = (part == 2'd2) ? {1'b0, msel[MAG_W-1:32]} : msel[31:0];
    rem_sh = {rem[ROOT_W:0], num[SQ_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    drs    = {drem, dvd[DVD_W-1]};
    dge    = drs >= {1'b0, root[31:0]};
  end

  always_comb begin
    status.started    = started;
    status.last       = last;
    status.last_in    = in_last;
    status.sq_done    = (comp == 2'd2) && (part == 2'd2);
    status.sqrt_done  = cnt == SQRT_LAST;
    status.div_done   = cnt == DIV_LAST;
    status.div_last   = comp == 2'd2;
    status.shift_done = (orv[MAG_W-1:31] == '0) && orv[30];
    status.unit_req   = normalize && (orv != '0);
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize <= 1'b0;
      started   <= 1'b0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) sums[i] <= '0;
    end else begin
      if (cfg_wen) normalize <= cfg_wdata;
      if (ctrl.cmd == CMD_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (ctrl.cmd)
        CMD_VERTEX: begin
          cur[0] <= in_x;
          cur[1] <= in_y;
          cur[2] <= in_z;
          last   <= in_last;
          if (!started) begin
            first[0] <= in_x; first[1] <= in_y; first[2] <= in_z;
            prev[0]  <= in_x; prev[1]  <= in_y; prev[2]  <= in_z;
          end
          started <= 1'b1;
        end
        CMD_PAIR_MUL: begin
          for (int i = 0; i < 3; i++) term[i] <= dif[i] * add[i];
        end
        CMD_PAIR_ADD: begin
          for (int i = 0; i < 3; i++) begin
            if (wovf[i]) begin
              sums[i] <= wsum[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
              sums[i] <= wsum[i][ACC_W-1:0];
            end
          end
          if (wovf != '0) sat <= 1'b1;
          if (!ctrl.pair_sel) prev <= cur;
        end
        CMD_EMIT: begin
          for (int i = 0; i < 3; i++) begin
            mag[i]  <= absv[i][ACC_W-1:1];
            neg[i]  <= sums[i][ACC_W-1];
            sums[i] <= '0;
          end
          ovf_keep <= sat;
          sat      <= 1'b0;
          started  <= 1'b0;
        end
        CMD_SQ_INIT: begin
          acc  <= '0;
          comp <= 2'd0;
          part <= 2'd0;
        end
        CMD_SQ_MUL: prod <= ACC_W'(op_a * op_b);
        CMD_SQ_ACC: begin
          // hi*hi at 2^64, cross term doubled at 2^33, lo*lo at 2^0
          unique case (part)
            2'd0:    acc <= acc + SQ_W'(prod);
            2'd1:    acc <= acc + (SQ_W'(prod) << 33);
            default: acc <= acc + (SQ_W'(prod) << 64);
          endcase
          if (part == 2'd2) begin
            part <= 2'd0;
            comp <= comp + 2'd1;
          end else begin
            part <= part + 2'd1;
          end
        end
        CMD_SQRT_INIT: begin
          num  <= acc;
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
          comp <= 2'd0;
        end
        CMD_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          num <= num << 2;
          cnt <= cnt + CNT_W'(1);
        end
        CMD_AREA: begin
          area_r <= root[MAG_W-1:0];
        end
        CMD_SHIFT: begin
          for (int i = 0; i < 3; i++)
            mag[i] <= (orv[MAG_W-1:31] != '0) ? (mag[i] >> 1) : (mag[i] << 1);
        end
        CMD_DIV_INIT: begin
          dvd  <= {msel[30:0], {UNIT_SHIFT{1'b0}}};
          drem <= '0;
          quo  <= '0;
          cnt  <= '0;
        end
        CMD_DIV: begin
          drem <= dge ? 32'(drs - {1'b0, root[31:0]}) : drs[31:0];
          quo  <= {quo[DVD_W-2:0], dge};
          dvd  <= dvd << 1;
          cnt  <= cnt + CNT_W'(1);
        end
        CMD_DIV_SAVE: begin
          mag[comp] <= (quo < FLUSH_LIMIT) ? '0 : MAG_W'(quo);
          comp      <= comp + 2'd1;
        end
        CMD_OUT: begin
          out_nx    <= (neg[0] && mag[0] != '0) ? -ACC_W'(mag[0]) : ACC_W'(mag[0]);
          out_ny    <= (neg[1] && mag[1] != '0) ? -ACC_W'(mag[1]) : ACC_W'(mag[1]);
          out_nz    <= (neg[2] && mag[2] != '0) ? -ACC_W'(mag[2]) : ACC_W'(mag[2]);
          out_area  <= area_r;
          out_ovf   <= ovf_keep;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/newell_polygon_normal_area.sv @@
// Newell polygon normal and area.
// Vertices arrive on s_* one per transfer (x, y, z packed in s_tdata, s_tlast on the
// final vertex). For each consecutive pair the three Newell terms are added into
// saturating 64-bit sums; the final vertex also adds the closing pair to the first.
// One result leaves on m_* per polygon: normal x/y/z and area in m_tdata, the
// saturation flag in m_tuser. cfg_wen/cfg_wdata set normalize (0: area vector,
// 1: unit normal in Q.30, tiny components flushed to zero).
// The first vertex of a polygon is only latched; each later non-final vertex is
// accepted, multiplied and accumulated before the next is taken. The final vertex
// holds the block in area mode: 9 shared 32x32 partial products for the squared
// length, then a 64-step bitwise square root. Normalize mode adds up to 32 one-bit
// scaling shifts, another square root and three 61-step restoring divisions.
// A new vertex is accepted while a result still waits in the output register; a
// stalled receiver only holds the block when the next result is ready to load.
// Reset (rst, synchronous) clears the sums, the polygon state and normalize.
`default_nettype none
module newell_polygon_normal_area import npna_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wen,
  input  wire         cfg_wdata,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [71:0]  s_tdata,   // point_x, point_y, point_z
  input  wire         s_tlast,   // last_point
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [255:0] m_tdata,  // normal_x, normal_y, normal_z, area, zero pad
  output logic        m_tuser    // overflow
);

  ctrl_t   ctrl;
  status_t status;
  logic signed [ACC_W-1:0] nx, ny, nz;
  logic [MAG_W-1:0]        area;

  npna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  npna_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_x      (s_tdata[23:0]),
    .in_y      (s_tdata[47:24]),
    .in_z      (s_tdata[71:48]),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_nx    (nx),
    .out_ny    (ny),
    .out_nz    (nz),
    .out_area  (area),
    .out_ovf   (m_tuser)
  );

  assign m_tdata = {1'b0, area, nz, ny, nx};

  // a final vertex always starts the multi-cycle result sequence
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input ready after final vertex");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmd == CMD_OUT) |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transfer");

  a_vertex_hs: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmd == CMD_VERTEX) |-> (s_tvalid && s_tready))
    else $error("vertex latched without transfer");

endmodule
`default_nettype wire
